[hdl/drsq_pkg.sv]
// shared types, constants and arithmetic helpers of the double reciprocal square root unit
// no dependencies: compile first
package drsq_pkg;

	localparam int SQRT_STAGES     = 27;
	localparam int RECIP_STAGES    = 27;
	localparam int ITERS_PER_STAGE = 2;

	localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
	localparam logic [63:0] POS_INF     = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] NEG_INF     = 64'hFFF0_0000_0000_0000;
	localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] POS_ZERO    = 64'h0;
	localparam logic [10:0] EXP_ALL_ONE = 11'h7FF;

	// beat flowing through the square root recurrence
	typedef struct packed {
		logic        valid;
		logic        eob;
		logic        spec;
		logic [63:0] spec_val;
		logic [10:0] rexp;
		logic [53:0] m;
		logic [57:0] r;
		logic [53:0] q;
	} sqrt_beat_t;

	// beat flowing through the reciprocal recurrence
	typedef struct packed {
		logic        valid;
		logic        eob;
		logic        spec;
		logic [63:0] spec_val;
		logic [10:0] se;
		logic        one;
		logic [52:0] sm;
		logic [53:0] rem;
		logic [53:0] q;
	} recip_beat_t;

	typedef struct packed {
		logic [57:0] r;
		logic [53:0] q;
	} sq_rq_t;

	typedef struct packed {
		logic [53:0] rem;
		logic [53:0] q;
	} rc_rq_t;

	typedef struct packed {
		logic        carry;
		logic [52:0] mant;
	} rnd_t;

	// one root digit: bring down a radicand pair, trial subtract
	function automatic sq_rq_t sqrt_iter(logic [57:0] r, logic [53:0] q, logic [1:0] pair);
		logic [57:0] rn;
		logic [57:0] t;
		sq_rq_t      o;
		rn = {r[55:0], pair};
		t  = {2'b00, q, 2'b01};
		if (rn >= t) begin
			o.r = rn - t;
			o.q = {q[52:0], 1'b1};
		end else begin
			o.r = rn;
			o.q = {q[52:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit of the restoring divide
	function automatic rc_rq_t recip_iter(logic [53:0] rem, logic [53:0] q, logic [52:0] sm);
		logic [53:0] rs;
		rc_rq_t      o;
		rs = {rem[52:0], 1'b0};
		if (rs >= {1'b0, sm}) begin
			o.rem = rs - {1'b0, sm};
			o.q   = {q[52:0], 1'b1};
		end else begin
			o.rem = rs;
			o.q   = {q[52:0], 1'b0};
		end
		return o;
	endfunction

	// round 53 bits plus guard to nearest even with sticky
	function automatic rnd_t round_ne(logic [53:0] q, logic sticky);
		logic [52:0] mant;
		logic        inc;
		logic [53:0] sum;
		rnd_t        o;
		mant = q[53:1];
		inc  = q[0] & (sticky | mant[0]);
		sum  = {1'b0, mant} + {53'd0, inc};
		o.carry = sum[53];
		o.mant  = sum[53] ? {1'b1, 52'd0} : sum[52:0];
		return o;
	endfunction

endpackage

[hdl/drsq_sqrt_pipe.sv]
// square root digit recurrence, two root bits per pipeline stage
// depends on drsq_pkg
module drsq_sqrt_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  drsq_pkg::sqrt_beat_t beat_in,
	output drsq_pkg::sqrt_beat_t beat_out
);
	import drsq_pkg::*;

	sqrt_beat_t stage_s [SQRT_STAGES];

	genvar g;
	generate
		for (g = 0; g < SQRT_STAGES; g++) begin : g_stage
			sqrt_beat_t prev;
			sqrt_beat_t nxt;

			if (g == 0) begin : g_first
				assign prev = beat_in;
			end else begin : g_rest
				assign prev = stage_s[g-1];
			end

			// two recurrence steps, radicand pairs taken from the top of m
			always_comb begin
				sq_rq_t rq;
				nxt = prev;
				for (int k = 0; k < ITERS_PER_STAGE; k++) begin
					rq    = sqrt_iter(nxt.r, nxt.q, nxt.m[53:52]);
					nxt.r = rq.r;
					nxt.q = rq.q;
					nxt.m = {nxt.m[51:0], 2'b00};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stage_s[g] <= '0;
				end else if (adv) begin
					stage_s[g] <= nxt;
				end
			end
		end
	endgenerate

	assign beat_out = stage_s[SQRT_STAGES-1];

endmodule

[hdl/drsq_recip_pipe.sv]
// restoring divide of one by the rounded root, two quotient bits per stage
// depends on drsq_pkg
module drsq_recip_pipe (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  drsq_pkg::recip_beat_t beat_in,
	output drsq_pkg::recip_beat_t beat_out
);
	import drsq_pkg::*;

	recip_beat_t stage_s [RECIP_STAGES];

	genvar g;
	generate
		for (g = 0; g < RECIP_STAGES; g++) begin : g_stage
			recip_beat_t prev;
			recip_beat_t nxt;

			if (g == 0) begin : g_first
				assign prev = beat_in;
			end else begin : g_rest
				assign prev = stage_s[g-1];
			end

			// two quotient bits
			always_comb begin
				rc_rq_t rq;
				nxt = prev;
				for (int k = 0; k < ITERS_PER_STAGE; k++) begin
					rq      = recip_iter(nxt.rem, nxt.q, nxt.sm);
					nxt.rem = rq.rem;
					nxt.q   = rq.q;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stage_s[g] <= '0;
				end else if (adv) begin
					stage_s[g] <= nxt;
				end
			end
		end
	endgenerate

	assign beat_out = stage_s[RECIP_STAGES-1];

endmodule

[hdl/double_reciprocal_sqrt_stream_unit.sv]
// top level of the double precision reciprocal square root stream unit
// depends on drsq_pkg, drsq_sqrt_pipe, drsq_recip_pipe
//
// usage:
//   input channel: operand (raw binary64) and end_of_batch, with in_valid/in_stall
//   output channel: result_value = 1/sqrt(operand), built as a rounded root followed
//   by a rounded reciprocal, and end_of_batch_out, with out_valid/out_stall
//   a beat is taken at a clock edge where valid is high and stall is low
//   throughput: one beat per cycle while the output is not stalled; the pipeline
//   holds up to 58 beats in flight
//   stage split: 2 decode/normalize stages, 27 root stages of two digits each,
//   1 root rounding stage, 27 divide stages of two quotient bits each, 1 output stage
//   the whole pipeline moves together; it advances whenever the output register is
//   empty or being taken, so in_stall is high only while out_valid && out_stall
//   a stall freezes every stage, nothing is dropped or repeated
//   reset (arst_n low) empties the pipeline; there is no other state to clear
module double_reciprocal_sqrt_stream_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] operand,
	input  logic        end_of_batch,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_value,
	output logic        end_of_batch_out
);
	import drsq_pkg::*;

	typedef struct packed {
		logic        valid;
		logic        eob;
		logic        spec;
		logic [63:0] spec_val;
		logic [10:0] ex;
		logic [51:0] fr;
		logic [5:0]  sh;
	} pre_beat_t;

	logic        adv;
	pre_beat_t   pre_s1;
	pre_beat_t   pre_c;
	sqrt_beat_t  pre_s2;
	sqrt_beat_t  norm_c;
	sqrt_beat_t  sqrt_out;
	recip_beat_t round_s30;
	recip_beat_t round_c;
	recip_beat_t recip_out;
	logic        out_valid_s58;
	logic        eob_s58;
	logic [63:0] result_s58;
	logic [63:0] final_c;

	// whole pipeline moves when the output slot is free or being drained
	assign adv      = !out_valid_s58 || !out_stall;
	assign in_stall = !adv;

	// stage 1: special cases and leading zero count of a subnormal fraction
	always_comb begin
		logic [10:0] ex;
		logic [51:0] fr;
		logic        neg;
		ex  = operand[62:52];
		fr  = operand[51:0];
		neg = operand[63];
		pre_c.valid = in_valid;
		pre_c.eob   = end_of_batch;
		pre_c.ex    = ex;
		pre_c.fr    = fr;
		pre_c.spec  = 1'b1;
		if (ex == EXP_ALL_ONE && fr != '0) begin
			pre_c.spec_val = operand | QUIET_BIT;
		end else if (ex == '0 && fr == '0) begin
			pre_c.spec_val = neg ? NEG_INF : POS_INF;
		end else if (neg) begin
			pre_c.spec_val = DEFAULT_NAN;
		end else if (ex == EXP_ALL_ONE) begin
			pre_c.spec_val = POS_ZERO;
		end else begin
			pre_c.spec     = 1'b0;
			pre_c.spec_val = POS_ZERO;
		end
		pre_c.sh = '0;
		for (int i = 0; i < 52; i++) begin
			if (fr[i]) pre_c.sh = 6'(52 - i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_s1 <= '0;
		end else if (adv) begin
			pre_s1 <= pre_c;
		end
	end

	// stage 2: normalize, make exponent even, seed the recurrence
	always_comb begin
		logic [52:0]        m53;
		logic signed [12:0] e;
		logic signed [12:0] e_even;
		logic [53:0]        m54;
		if (pre_s1.ex == '0) begin
			m53 = {1'b0, pre_s1.fr} << pre_s1.sh;
			e   = -13'sd1074 - $signed({7'd0, pre_s1.sh});
		end else begin
			m53 = {1'b1, pre_s1.fr};
			e   = $signed({2'b00, pre_s1.ex}) - 13'sd1075;
		end
		if (e[0]) begin
			m54    = {m53, 1'b0};
			e_even = e - 13'sd1;
		end else begin
			m54    = {1'b0, m53};
			e_even = e;
		end
		norm_c.valid    = pre_s1.valid;
		norm_c.eob      = pre_s1.eob;
		norm_c.spec     = pre_s1.spec;
		norm_c.spec_val = pre_s1.spec_val;
		norm_c.rexp     = 11'((e_even >>> 1) + 13'sd1049);
		norm_c.m        = m54;
		norm_c.r        = '0;
		norm_c.q        = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_s2 <= '0;
		end else if (adv) begin
			pre_s2 <= norm_c;
		end
	end

	// stages 3 to 29: root digits
	drsq_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.beat_in  (pre_s2),
		.beat_out (sqrt_out)
	);

	// stage 30: round the root, seed the divide
	always_comb begin
		rnd_t rr;
		rr = round_ne(sqrt_out.q, sqrt_out.r != '0);
		round_c.valid    = sqrt_out.valid;
		round_c.eob      = sqrt_out.eob;
		round_c.spec     = sqrt_out.spec;
		round_c.spec_val = sqrt_out.spec_val;
		round_c.se       = sqrt_out.rexp + {10'd0, rr.carry};
		round_c.one      = (rr.mant[51:0] == '0);
		round_c.sm       = {1'b1, rr.mant[51:0]};
		round_c.rem      = {2'b01, 52'd0};
		round_c.q        = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_s30 <= '0;
		end else if (adv) begin
			round_s30 <= round_c;
		end
	end

	// stages 31 to 57: quotient bits
	drsq_recip_pipe u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.beat_in  (round_s30),
		.beat_out (recip_out)
	);

	// stage 58: round the quotient and assemble the result
	always_comb begin
		rnd_t        rr;
		logic [10:0] bexp;
		rr   = round_ne(recip_out.q, recip_out.rem != '0);
		bexp = 11'd2045 - recip_out.se + {10'd0, rr.carry};
		if (recip_out.spec) begin
			final_c = recip_out.spec_val;
		end else if (recip_out.one) begin
			final_c = {1'b0, 11'd2046 - recip_out.se, 52'd0};
		end else begin
			final_c = {1'b0, bexp, rr.mant[51:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s58 <= 1'b0;
			eob_s58       <= 1'b0;
			result_s58    <= '0;
		end else if (adv) begin
			out_valid_s58 <= recip_out.valid;
			eob_s58       <= recip_out.eob;
			result_s58    <= final_c;
		end
	end

	assign out_valid        = out_valid_s58;
	assign end_of_batch_out = eob_s58;
	assign result_value     = result_s58;

endmodule

[hdl/drsq_checker.sv]
// port level checks of the reciprocal square root stream unit, bound to the top level
// depends on double_reciprocal_sqrt_stream_unit
module drsq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] result_value,
	input logic        end_of_batch_out
);

	// input is held back exactly when a finished result waits
	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output backpressure");

	// a waiting result keeps its beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value)
			&& $stable(end_of_batch_out))
		else $error("stalled output beat changed");

	// an empty output slot never holds back the input
	a_frozen_no_new: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("stall raised without a pending output beat");

endmodule

bind double_reciprocal_sqrt_stream_unit drsq_checker u_drsq_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the double reciprocal square root stream unit
// depends on drsq_pkg and double_reciprocal_sqrt_stream_unit; predicts 1/sqrt bit for bit
`timescale 1ns / 100ps

module testbench;
	import drsq_pkg::*;

	localparam logic [63:0] FRAC_MASK  = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [63:0] HIDDEN_BIT = 64'h0010_0000_0000_0000;
	localparam int PIPE_DEPTH = 58;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] operand = '0;
	logic        end_of_batch = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] result_value;
	logic        end_of_batch_out;

	typedef struct packed {
		logic [63:0] value;
		logic        eob;
	} rsqrt_beat_t;

	rsqrt_beat_t pending_results[$];
	int          error_count = 0;
	int          beats_sent = 0;
	int          beats_checked = 0;
	int          stall_left = 0;
	bit          quiet_mode = 1'b0;
	bit          hold_off = 1'b0;

	double_reciprocal_sqrt_stream_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operand          (operand),
		.end_of_batch     (end_of_batch),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_value     (result_value),
		.end_of_batch_out (end_of_batch_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// round 53 bits plus guard to nearest even; carry flags overflow to 2^53
	function automatic logic [52:0] round_even(input logic [53:0] q, input bit sticky,
			output bit carry);
		logic [53:0] mant;
		mant = {1'b0, q[53:1]};
		carry = 1'b0;
		if (q[0] && (sticky || mant[0])) begin
			mant = mant + 54'd1;
			if (mant[53]) begin
				mant = mant >> 1;
				carry = 1'b1;
			end
		end
		return mant[52:0];
	endfunction

	// correctly rounded root of a positive finite nonzero pattern
	function automatic logic [63:0] root_bits(input logic [63:0] x);
		logic [63:0] m, q, r, t, pair, bexp;
		logic [52:0] mant;
		int          e, p;
		bit          carry;
		q = 0;
		r = 0;
		if (x[62:52] == 0) begin
			m = x & FRAC_MASK;
			e = -1074;
			while (m < HIDDEN_BIT) begin
				m = m << 1;
				e--;
			end
		end else begin
			m = (x & FRAC_MASK) | HIDDEN_BIT;
			e = int'(x[62:52]) - 1075;
		end
		if (e % 2 != 0) begin
			m = m << 1;
			e--;
		end
		for (int i = 53; i >= 0; i--) begin
			p = 2 * i - 54;
			pair = (p >= 0) ? ((m >> p) & 64'd3) : 64'd0;
			r = (r << 2) | pair;
			t = (q << 2) | 64'd1;
			if (r >= t) begin
				r = r - t;
				q = (q << 1) | 64'd1;
			end else begin
				q = q << 1;
			end
		end
		mant = round_even(q[53:0], r != 0, carry);
		bexp = 64'(e / 2 + 1049) + (carry ? 64'd1 : 64'd0);
		return (bexp << 52) | ({11'd0, mant} & FRAC_MASK);
	endfunction

	// correctly rounded reciprocal of a positive normal pattern
	function automatic logic [63:0] recip_bits(input logic [63:0] s);
		logic [63:0] se, sm, q, rem, bexp;
		logic [52:0] mant;
		bit          carry;
		se = {53'd0, s[62:52]};
		sm = (s & FRAC_MASK) | HIDDEN_BIT;
		q = 0;
		rem = HIDDEN_BIT;
		if (sm == HIDDEN_BIT)
			return (64'd2046 - se) << 52;
		for (int i = 0; i < 54; i++) begin
			rem = rem << 1;
			if (rem >= sm) begin
				rem = rem - sm;
				q = (q << 1) | 64'd1;
			end else begin
				q = q << 1;
			end
		end
		mant = round_even(q[53:0], rem != 0, carry);
		bexp = 64'd2045 - se + (carry ? 64'd1 : 64'd0);
		return (bexp << 52) | ({11'd0, mant} & FRAC_MASK);
	endfunction

	function automatic logic [63:0] predict_rsqrt(input logic [63:0] x);
		if (x[62:52] == EXP_ALL_ONE && x[51:0] != 0) return x | QUIET_BIT;
		if (x[62:0] == 0) return x[63] ? NEG_INF : POS_INF;
		if (x[63]) return DEFAULT_NAN;
		if (x[62:52] == EXP_ALL_ONE) return POS_ZERO;
		return recip_bits(root_bits(x));
	endfunction

	// send one beat, with a random gap first unless quiet
	task automatic send_operand(input logic [63:0] x, input bit eob);
		rsqrt_beat_t exp_beat;
		if (!quiet_mode && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 7)) @(negedge clk);
		operand = x;
		end_of_batch = eob;
		in_valid = 1'b1;
		exp_beat.value = predict_rsqrt(x);
		exp_beat.eob = eob;
		pending_results.push_back(exp_beat);
		do @(posedge clk); while (in_stall);
		beats_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// random pattern biased toward interesting exponents and fractions
	function automatic logic [63:0] random_operand();
		logic [63:0] x;
		x = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: x[62:52] = 11'd0;
			1: x[62:52] = EXP_ALL_ONE;
			2: x[51:0] = 52'd0;
			3: x[51:0] = {52{1'b1}};
			4: x[62:52] = 11'($urandom_range(1, 4));
			5: x[62:52] = 11'($urandom_range(2040, 2046));
			default: x[63] = ($urandom_range(0, 7) == 0);
		endcase
		return x;
	endfunction

	// receiver: random stall bursts, a long hold-off on request
	always @(negedge clk) begin
		if (hold_off) begin
			out_stall <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		rsqrt_beat_t exp_beat;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat value=%h", result_value);
				error_count++;
			end else begin
				exp_beat = pending_results.pop_front();
				beats_checked++;
				if (result_value !== exp_beat.value) begin
					$error("result_value expected %h actual %h", exp_beat.value,
						result_value);
					error_count++;
				end
				if (end_of_batch_out !== exp_beat.eob) begin
					$error("end_of_batch_out expected %b actual %b", exp_beat.eob,
						end_of_batch_out);
					error_count++;
				end
			end
		end
	end

	task automatic test_special_values();
		send_operand(64'h0000_0000_0000_0000, 1'b0);
		send_operand(64'h8000_0000_0000_0000, 1'b0);
		send_operand(64'h7FF0_0000_0000_0000, 1'b0);
		send_operand(64'hFFF0_0000_0000_0000, 1'b0);
		send_operand(64'h7FF0_0000_0000_0001, 1'b1);
		send_operand(64'hFFF4_0000_0000_00AB, 1'b0);
		send_operand(64'h7FF8_0000_0000_0000, 1'b0);
		send_operand(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_operand(64'hBFF0_0000_0000_0000, 1'b0);
		send_operand(64'h8000_0000_0000_0001, 1'b0);
	endtask

	task automatic test_extreme_magnitudes();
		send_operand(64'h0000_0000_0000_0001, 1'b0);
		send_operand(64'h000F_FFFF_FFFF_FFFF, 1'b0);
		send_operand(64'h0000_0000_0000_0002, 1'b1);
		send_operand(64'h0010_0000_0000_0000, 1'b0);
		send_operand(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
		send_operand(64'h3FF0_0000_0000_0000, 1'b0);
		send_operand(64'h4010_0000_0000_0000, 1'b1);
		send_operand(64'h4000_0000_0000_0000, 1'b0);
		send_operand(64'h3FEF_FFFF_FFFF_FFFF, 1'b0);
		send_operand(64'h3FF0_0000_0000_0001, 1'b1);
	endtask

	// long receiver hold-off while the sender keeps offering beats
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (200) @(negedge clk);
				hold_off = 1'b0;
			end
			repeat (90) send_operand(random_operand(), 1'($urandom_range(0, 1)));
		join
	endtask

	task automatic test_random_stream(input int count);
		repeat (count) send_operand(random_operand(), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_special_values();
		test_extreme_magnitudes();
		test_backpressure();
		test_random_stream(1000);
		quiet_mode = 1'b1;
		test_random_stream(250);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 10) @(negedge clk);
		$display("covered %0d beats: zeros, infinities, NaNs, negatives, subnormals,",
			beats_sent);
		$display("extreme normals, random patterns, stalls; %0d results compared",
			beats_checked);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#400000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

[filelist.f]
hdl/drsq_pkg.sv
hdl/drsq_sqrt_pipe.sv
hdl/drsq_recip_pipe.sv
hdl/double_reciprocal_sqrt_stream_unit.sv
hdl/drsq_checker.sv
tb/testbench.sv
